/* hdl/ltgs_pkg.sv */
// Shared constants, command/status structs and state types for the LDA token sampler.
// Used by the controller, the datapath, the term unit and the top level.
package ltgs_pkg;

  localparam int NUM_TOPICS  = 64;
  localparam int DOC_DEPTH   = 1024;
  localparam int VOCAB_DEPTH = 8192;

  localparam int TOPIC_W = 6;
  localparam int DOC_W   = 10;
  localparam int WORD_W  = 13;
  localparam int ACT_W   = 2;
  localparam int CFG_IW  = 2;
  localparam int DOC_AW  = DOC_W + TOPIC_W;
  localparam int WORD_AW = WORD_W + TOPIC_W;
  localparam int CLR_W   = WORD_AW;

  localparam int CNT_W   = 24;
  localparam int WT_W    = 16;
  localparam int FRAC_W  = 16;
  localparam int PRIOR_W = 24;
  localparam int VOCAB_W = 14;
  localparam int BV_W    = PRIOR_W + VOCAB_W;
  localparam int OPA_W   = CNT_W + FRAC_W + 1;
  localparam int PROD_W  = 2 * OPA_W + WT_W;
  localparam int TERM_W  = 48;
  localparam int CUM_W   = 56;
  localparam int STEP_W  = 6;

  localparam logic [CNT_W-1:0]  CNT_MAX  = '1;
  localparam logic [TERM_W-1:0] TERM_MAX = '1;
  localparam logic [CUM_W-1:0]  CUM_MAX  = '1;

  localparam logic [PRIOR_W-1:0] ALPHA_RESET = 24'd6554;
  localparam logic [PRIOR_W-1:0] BETA_RESET  = 24'd655;
  localparam logic [VOCAB_W-1:0] VOCAB_RESET = 14'd8192;

  localparam logic [ACT_W-1:0] ACT_COUNT    = 2'd0;
  localparam logic [ACT_W-1:0] ACT_WEIGHT   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_RESAMPLE = 2'd2;
  localparam logic [ACT_W-1:0] ACT_UNUSED   = 2'd3;

  localparam logic [CFG_IW-1:0] CFG_ALPHA = 2'd0;
  localparam logic [CFG_IW-1:0] CFG_BETA  = 2'd1;
  localparam logic [CFG_IW-1:0] CFG_VOCAB = 2'd2;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DECODE, S_DEC_RD, S_DEC_WR, S_TERM_RD, S_TERM_GO,
    S_TERM_RUN, S_POS, S_SRCH_RD, S_SRCH_CMP, S_INC_RD, S_INC_WR, S_DONE
  } ctrl_state_t;

  typedef enum logic [2:0] {
    T_IDLE, T_MUL_DP, T_MUL_B, T_DIV_CHK, T_DIV
  } term_state_t;

  typedef struct packed {
    logic clear_en;
    logic latch;
    logic wt_wr;
    logic rd_en;
    logic dec_wr;
    logic inc_wr;
    logic taddr_zero;
    logic taddr_inc;
    logic sum_clr;
    logic term_start;
    logic acc_en;
    logic pos_calc;
    logic cum_rd;
    logic srch_cmp;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic             clear_last;
    logic [ACT_W-1:0] act;
    logic             in_range;
    logic             taddr_last;
    logic             term_done;
    logic             term_idle;
    logic             hit;
    logic             out_busy;
  } status_t;

endpackage

/* hdl/lda_token_gibbs_sampler_core.sv */
// LDA token Gibbs sampler, top level: controller plus datapath.
// Depends on ltgs_pkg, ltgs_ctrl, ltgs_datapath (with ltgs_term_unit).
//
// Input transaction: in_valid with action, doc_index, word_index, topic_in,
// doc_weight, uniform_draw; taken when in_valid is high and in_stall low.
// Each input transaction gives exactly one output transaction (topic_out,
// count_error), taken when out_valid is high and out_stall low.
// Configuration: cfg_valid/cfg_ready with cfg_index (0 alpha, 1 beta,
// 2 vocab size) and cfg_data; cfg_ready is always high. Write only while idle.
// One item is processed at a time. A count action passes decode, a read and a
// write of the count memories and the done state before out_valid rises; a
// weight or ignored action only decode and done. in_stall falls as out_valid
// rises, so the next item can be taken from then on. A resample walks all 64
// topics (memory read and start, then the bit-serial term unit: 16 + 41 multiply
// steps, range check, 48 divide steps, done pulse), then searches the cumulative
// list topic by topic, a read and a compare each, until a hit. Saturating terms
// and a zero divisor skip the divide. After reset a clearing pass zeroes the
// count memories; in_stall stays high during it. A stalled result is held in
// the output register; the next item is accepted meanwhile, waiting at the end.
module lda_token_gibbs_sampler_core (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [ltgs_pkg::ACT_W-1:0]     action,
  input  logic [ltgs_pkg::DOC_W-1:0]     doc_index,
  input  logic [ltgs_pkg::WORD_W-1:0]    word_index,
  input  logic [ltgs_pkg::TOPIC_W-1:0]   topic_in,
  input  logic [ltgs_pkg::WT_W-1:0]      doc_weight,
  input  logic [ltgs_pkg::WT_W-1:0]      uniform_draw,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [ltgs_pkg::TOPIC_W-1:0]   topic_out,
  output logic                           count_error,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [ltgs_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [ltgs_pkg::PRIOR_W-1:0]   cfg_data
);

  ltgs_pkg::cmd_t    cmd;
  ltgs_pkg::status_t st;

  assign cfg_ready = 1'b1;

  ltgs_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  ltgs_datapath u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .st           (st),
    .action       (action),
    .doc_index    (doc_index),
    .word_index   (word_index),
    .topic_in     (topic_in),
    .doc_weight   (doc_weight),
    .uniform_draw (uniform_draw),
    .cfg_write    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .topic_out    (topic_out),
    .count_error  (count_error)
  );

endmodule

/* hdl/ltgs_term_unit.sv */
// Bit-serial unit for one topic weight: (A*dp)*B by shift-add, then restoring divide by D.
// Depends on ltgs_pkg.
module ltgs_term_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  input  logic [ltgs_pkg::CNT_W-1:0]     cd,
  input  logic [ltgs_pkg::CNT_W-1:0]     cw,
  input  logic [ltgs_pkg::CNT_W-1:0]     ck,
  input  logic [ltgs_pkg::WT_W-1:0]      dp,
  input  logic [ltgs_pkg::PRIOR_W-1:0]   alpha,
  input  logic [ltgs_pkg::PRIOR_W-1:0]   beta,
  input  logic [ltgs_pkg::BV_W-1:0]      bv,
  output logic                           idle,
  output logic                           done,
  output logic [ltgs_pkg::TERM_W-1:0]    term
);

  localparam int HI_LO = ltgs_pkg::FRAC_W + ltgs_pkg::TERM_W;

  ltgs_pkg::term_state_t tstate;
  logic [ltgs_pkg::PROD_W-1:0] acc;
  logic [ltgs_pkg::PROD_W-1:0] mcand;
  logic [ltgs_pkg::OPA_W-1:0]  mplier;
  logic [ltgs_pkg::OPA_W-1:0]  b_op;
  logic [ltgs_pkg::OPA_W-1:0]  d_op;
  logic [ltgs_pkg::OPA_W:0]    rem;
  logic [ltgs_pkg::TERM_W-1:0] quo;
  logic [ltgs_pkg::STEP_W-1:0] step;

  logic [ltgs_pkg::OPA_W-1:0]  a_val, b_val, d_val;
  logic [ltgs_pkg::PROD_W-1:0] acc_add;
  logic [ltgs_pkg::OPA_W:0]    trial;
  logic                        fits;
  logic [ltgs_pkg::TERM_W-1:0] quo_next;

  assign a_val = {1'b0, cd, {ltgs_pkg::FRAC_W{1'b0}}} + ltgs_pkg::OPA_W'(alpha);
  assign b_val = {1'b0, cw, {ltgs_pkg::FRAC_W{1'b0}}} + ltgs_pkg::OPA_W'(beta);
  assign d_val = {1'b0, ck, {ltgs_pkg::FRAC_W{1'b0}}} + ltgs_pkg::OPA_W'(bv);
  assign acc_add = mplier[0] ? acc + mcand : acc;
  assign trial = {rem[ltgs_pkg::OPA_W-1:0], acc[HI_LO-1]};
  assign fits = trial >= {1'b0, d_op};
  assign quo_next = {quo[ltgs_pkg::TERM_W-2:0], fits};
  assign idle = (tstate == ltgs_pkg::T_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      tstate <= ltgs_pkg::T_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (tstate)
        ltgs_pkg::T_IDLE: begin
          if (start) begin
            tstate <= ltgs_pkg::T_MUL_DP;
          end
        end
        ltgs_pkg::T_MUL_DP: begin
          if (step == '0) begin
            tstate <= ltgs_pkg::T_MUL_B;
          end
        end
        ltgs_pkg::T_MUL_B: begin
          if (step == '0) begin
            tstate <= ltgs_pkg::T_DIV_CHK;
          end
        end
        ltgs_pkg::T_DIV_CHK: begin
          if (d_op == '0 || acc[ltgs_pkg::PROD_W-1:HI_LO] >= d_op) begin
            tstate <= ltgs_pkg::T_IDLE;
            done <= 1'b1;
          end else begin
            tstate <= ltgs_pkg::T_DIV;
          end
        end
        ltgs_pkg::T_DIV: begin
          if (step == '0) begin
            tstate <= ltgs_pkg::T_IDLE;
            done <= 1'b1;
          end
        end
        default: tstate <= ltgs_pkg::T_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (tstate)
      ltgs_pkg::T_IDLE: begin
        if (start) begin
          acc <= '0;
          mcand <= ltgs_pkg::PROD_W'(a_val);
          mplier <= ltgs_pkg::OPA_W'(dp);
          b_op <= b_val;
          d_op <= d_val;
          step <= ltgs_pkg::STEP_W'(ltgs_pkg::WT_W - 1);
        end
      end
      ltgs_pkg::T_MUL_DP: begin
        step <= step - 1'b1;
        if (step == '0) begin
          acc <= '0;
          mcand <= acc_add;
          mplier <= b_op;
          step <= ltgs_pkg::STEP_W'(ltgs_pkg::OPA_W - 1);
        end else begin
          acc <= acc_add;
          mcand <= mcand << 1;
          mplier <= mplier >> 1;
        end
      end
      ltgs_pkg::T_MUL_B: begin
        acc <= acc_add;
        mcand <= mcand << 1;
        mplier <= mplier >> 1;
        step <= step - 1'b1;
      end
      ltgs_pkg::T_DIV_CHK: begin
        if (d_op == '0) begin
          term <= (acc == '0) ? '0 : ltgs_pkg::TERM_MAX;
        end else if (acc[ltgs_pkg::PROD_W-1:HI_LO] >= d_op) begin
          term <= ltgs_pkg::TERM_MAX;
        end
        rem <= (ltgs_pkg::OPA_W + 1)'(acc[ltgs_pkg::PROD_W-1:HI_LO]);
        quo <= '0;
        step <= ltgs_pkg::STEP_W'(ltgs_pkg::TERM_W - 1);
      end
      ltgs_pkg::T_DIV: begin
        rem <= fits ? trial - {1'b0, d_op} : trial;
        quo <= quo_next;
        acc <= acc << 1;
        step <= step - 1'b1;
        if (step == '0) begin
          term <= quo_next;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

/* hdl/ltgs_datapath.sv */
// Datapath: configuration registers, count/weight/cumulative memories, search and output register.
// Depends on ltgs_pkg and ltgs_term_unit.
module ltgs_datapath (
  input  logic                           clk,
  input  logic                           rst,
  input  ltgs_pkg::cmd_t                 cmd,
  output ltgs_pkg::status_t              st,
  input  logic [ltgs_pkg::ACT_W-1:0]     action,
  input  logic [ltgs_pkg::DOC_W-1:0]     doc_index,
  input  logic [ltgs_pkg::WORD_W-1:0]    word_index,
  input  logic [ltgs_pkg::TOPIC_W-1:0]   topic_in,
  input  logic [ltgs_pkg::WT_W-1:0]      doc_weight,
  input  logic [ltgs_pkg::WT_W-1:0]      uniform_draw,
  input  logic                           cfg_write,
  input  logic [ltgs_pkg::CFG_IW-1:0]    cfg_index,
  input  logic [ltgs_pkg::PRIOR_W-1:0]   cfg_data,
  input  logic                           out_stall,
  output logic                           out_valid,
  output logic [ltgs_pkg::TOPIC_W-1:0]   topic_out,
  output logic                           count_error
);

  logic [ltgs_pkg::CNT_W-1:0] dtc_mem [ltgs_pkg::DOC_DEPTH*ltgs_pkg::NUM_TOPICS];
  logic [ltgs_pkg::CNT_W-1:0] wtc_mem [ltgs_pkg::VOCAB_DEPTH*ltgs_pkg::NUM_TOPICS];
  logic [ltgs_pkg::CNT_W-1:0] tt_mem  [ltgs_pkg::NUM_TOPICS];
  logic [ltgs_pkg::WT_W-1:0]  dtw_mem [ltgs_pkg::DOC_DEPTH*ltgs_pkg::NUM_TOPICS];
  logic [ltgs_pkg::CUM_W-1:0] cum_mem [ltgs_pkg::NUM_TOPICS];

  logic [ltgs_pkg::PRIOR_W-1:0] alpha, beta;
  logic [ltgs_pkg::VOCAB_W-1:0] vocab;
  logic [ltgs_pkg::BV_W-1:0]    bv;

  logic [ltgs_pkg::ACT_W-1:0]   act_q;
  logic [ltgs_pkg::DOC_W-1:0]   doc_q;
  logic [ltgs_pkg::WORD_W-1:0]  word_q;
  logic [ltgs_pkg::TOPIC_W-1:0] tin_q;
  logic [ltgs_pkg::WT_W-1:0]    wt_q;
  logic [ltgs_pkg::WT_W-1:0]    u_q;

  logic [ltgs_pkg::TOPIC_W-1:0] taddr, rd_topic, res_topic;
  logic [ltgs_pkg::CLR_W-1:0]   clr_cnt;
  logic [ltgs_pkg::CNT_W-1:0]   cd_q, cw_q, ck_q;
  logic [ltgs_pkg::WT_W-1:0]    dp_q;
  logic [ltgs_pkg::CUM_W-1:0]   cum_q, sum, pos;
  logic                         err;

  logic [ltgs_pkg::CNT_W-1:0]   cd_new, cw_new, ck_new;
  logic [ltgs_pkg::CUM_W:0]     sum_ext;
  logic [ltgs_pkg::CUM_W-1:0]   sum_next, p_hi, pos_next;
  logic [2*ltgs_pkg::WT_W-1:0]  p_lo;
  logic [ltgs_pkg::TERM_W-1:0]  term;
  logic                         term_done, term_idle, cnt_wr, hit;

  localparam logic [ltgs_pkg::TOPIC_W-1:0] LAST_TOPIC =
    ltgs_pkg::TOPIC_W'(ltgs_pkg::NUM_TOPICS - 1);

  function automatic logic [ltgs_pkg::CNT_W-1:0] step_cnt(
    input logic [ltgs_pkg::CNT_W-1:0] c, input logic down);
    if (down) begin
      return (c == '0) ? '0 : c - 1'b1;
    end
    return (c == ltgs_pkg::CNT_MAX) ? c : c + 1'b1;
  endfunction

  assign cnt_wr = cmd.dec_wr | cmd.inc_wr;
  assign cd_new = step_cnt(cd_q, cmd.dec_wr);
  assign cw_new = step_cnt(cw_q, cmd.dec_wr);
  assign ck_new = step_cnt(ck_q, cmd.dec_wr);

  assign sum_ext  = {1'b0, sum} + (ltgs_pkg::CUM_W + 1)'(term);
  assign sum_next = sum_ext[ltgs_pkg::CUM_W] ? ltgs_pkg::CUM_MAX
                                             : sum_ext[ltgs_pkg::CUM_W-1:0];
  assign p_hi     = sum[ltgs_pkg::CUM_W-1:ltgs_pkg::FRAC_W] * u_q;
  assign p_lo     = sum[ltgs_pkg::FRAC_W-1:0] * u_q;
  assign pos_next = p_hi + ltgs_pkg::CUM_W'(p_lo[2*ltgs_pkg::WT_W-1:ltgs_pkg::FRAC_W]);
  assign hit      = (pos <= cum_q) || (rd_topic == LAST_TOPIC);

  assign st.clear_last = (clr_cnt == '1);
  assign st.act        = act_q;
  assign st.in_range   = (32'(doc_q) < ltgs_pkg::DOC_DEPTH) &&
                         (32'(word_q) < ltgs_pkg::VOCAB_DEPTH) &&
                         (32'(tin_q) < ltgs_pkg::NUM_TOPICS);
  assign st.taddr_last = (taddr == LAST_TOPIC);
  assign st.term_done  = term_done;
  assign st.term_idle  = term_idle;
  assign st.hit        = hit;
  assign st.out_busy   = out_valid && out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      alpha <= ltgs_pkg::ALPHA_RESET;
      beta  <= ltgs_pkg::BETA_RESET;
      vocab <= ltgs_pkg::VOCAB_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ltgs_pkg::CFG_ALPHA: alpha <= cfg_data;
        ltgs_pkg::CFG_BETA:  beta  <= cfg_data;
        ltgs_pkg::CFG_VOCAB: vocab <= cfg_data[ltgs_pkg::VOCAB_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    bv <= beta * vocab;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clear_en) begin
      clr_cnt <= clr_cnt + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_q  <= action;
      doc_q  <= doc_index;
      word_q <= word_index;
      tin_q  <= topic_in;
      wt_q   <= doc_weight;
      u_q    <= uniform_draw;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      taddr <= topic_in;
    end else if (cmd.taddr_zero) begin
      taddr <= '0;
    end else if (cmd.srch_cmp && hit) begin
      taddr <= rd_topic;
    end else if (cmd.taddr_inc) begin
      taddr <= taddr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en || cmd.cum_rd) begin
      rd_topic <= taddr;
    end
    if (cmd.latch) begin
      res_topic <= topic_in;
    end else if (cmd.srch_cmp && hit) begin
      res_topic <= rd_topic;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      dtc_mem[clr_cnt[ltgs_pkg::DOC_AW-1:0]] <= '0;
    end else if (cnt_wr) begin
      dtc_mem[{doc_q, rd_topic}] <= cd_new;
    end
    if (cmd.rd_en) begin
      cd_q <= dtc_mem[{doc_q, taddr}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      wtc_mem[clr_cnt] <= '0;
    end else if (cnt_wr) begin
      wtc_mem[{word_q, rd_topic}] <= cw_new;
    end
    if (cmd.rd_en) begin
      cw_q <= wtc_mem[{word_q, taddr}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear_en) begin
      tt_mem[clr_cnt[ltgs_pkg::TOPIC_W-1:0]] <= '0;
    end else if (cnt_wr) begin
      tt_mem[rd_topic] <= ck_new;
    end
    if (cmd.rd_en) begin
      ck_q <= tt_mem[taddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.wt_wr) begin
      dtw_mem[{doc_q, tin_q}] <= wt_q;
    end
    if (cmd.rd_en) begin
      dp_q <= dtw_mem[{doc_q, taddr}];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.acc_en) begin
      cum_mem[rd_topic] <= sum_next;
    end
    if (cmd.cum_rd) begin
      cum_q <= cum_mem[taddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_clr) begin
      sum <= '0;
    end else if (cmd.acc_en) begin
      sum <= sum_next;
    end
    if (cmd.pos_calc) begin
      pos <= pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      err <= 1'b0;
    end else if (cmd.dec_wr && (cd_q == '0 || cw_q == '0 || ck_q == '0)) begin
      err <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      topic_out   <= res_topic;
      count_error <= err;
    end
  end

  ltgs_term_unit u_term (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.term_start),
    .cd    (cd_q),
    .cw    (cw_q),
    .ck    (ck_q),
    .dp    (dp_q),
    .alpha (alpha),
    .beta  (beta),
    .bv    (bv),
    .idle  (term_idle),
    .done  (term_done),
    .term  (term)
  );

endmodule

/* hdl/ltgs_ctrl.sv */
// Controller state machine: sequences clearing, count updates, topic walk and search.
// Depends on ltgs_pkg; drives the datapath through cmd_t, reads status_t.
module ltgs_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  ltgs_pkg::status_t  st,
  output ltgs_pkg::cmd_t     cmd
);

  ltgs_pkg::ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ltgs_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  assign in_stall = (state != ltgs_pkg::S_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    unique case (state)
      ltgs_pkg::S_CLEAR: begin
        cmd.clear_en = 1'b1;
        if (st.clear_last) begin
          state_next = ltgs_pkg::S_IDLE;
        end
      end
      ltgs_pkg::S_IDLE: begin
        if (in_valid) begin
          cmd.latch = 1'b1;
          state_next = ltgs_pkg::S_DECODE;
        end
      end
      ltgs_pkg::S_DECODE: begin
        if (!st.in_range) begin
          state_next = ltgs_pkg::S_DONE;
        end else begin
          case (st.act)
            ltgs_pkg::ACT_COUNT: state_next = ltgs_pkg::S_INC_RD;
            ltgs_pkg::ACT_WEIGHT: begin
              cmd.wt_wr = 1'b1;
              state_next = ltgs_pkg::S_DONE;
            end
            ltgs_pkg::ACT_RESAMPLE: state_next = ltgs_pkg::S_DEC_RD;
            default: state_next = ltgs_pkg::S_DONE;
          endcase
        end
      end
      ltgs_pkg::S_DEC_RD: begin
        cmd.rd_en = 1'b1;
        state_next = ltgs_pkg::S_DEC_WR;
      end
      ltgs_pkg::S_DEC_WR: begin
        cmd.dec_wr = 1'b1;
        cmd.taddr_zero = 1'b1;
        cmd.sum_clr = 1'b1;
        state_next = ltgs_pkg::S_TERM_RD;
      end
      ltgs_pkg::S_TERM_RD: begin
        cmd.rd_en = 1'b1;
        state_next = ltgs_pkg::S_TERM_GO;
      end
      ltgs_pkg::S_TERM_GO: begin
        cmd.term_start = 1'b1;
        state_next = ltgs_pkg::S_TERM_RUN;
      end
      ltgs_pkg::S_TERM_RUN: begin
        if (st.term_done) begin
          cmd.acc_en = 1'b1;
          if (st.taddr_last) begin
            cmd.taddr_zero = 1'b1;
            state_next = ltgs_pkg::S_POS;
          end else begin
            cmd.taddr_inc = 1'b1;
            state_next = ltgs_pkg::S_TERM_RD;
          end
        end
      end
      ltgs_pkg::S_POS: begin
        cmd.pos_calc = 1'b1;
        state_next = ltgs_pkg::S_SRCH_RD;
      end
      ltgs_pkg::S_SRCH_RD: begin
        cmd.cum_rd = 1'b1;
        state_next = ltgs_pkg::S_SRCH_CMP;
      end
      ltgs_pkg::S_SRCH_CMP: begin
        cmd.srch_cmp = 1'b1;
        if (st.hit) begin
          state_next = ltgs_pkg::S_INC_RD;
        end else begin
          cmd.taddr_inc = 1'b1;
          state_next = ltgs_pkg::S_SRCH_RD;
        end
      end
      ltgs_pkg::S_INC_RD: begin
        cmd.rd_en = 1'b1;
        state_next = ltgs_pkg::S_INC_WR;
      end
      ltgs_pkg::S_INC_WR: begin
        cmd.inc_wr = 1'b1;
        state_next = ltgs_pkg::S_DONE;
      end
      ltgs_pkg::S_DONE: begin
        if (!st.out_busy) begin
          cmd.out_load = 1'b1;
          state_next = ltgs_pkg::S_IDLE;
        end
      end
      default: state_next = ltgs_pkg::S_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second transaction accepted while busy");
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !st.out_busy)
    else $error("result loaded over a stalled result");
  a_term_free: assert property (@(posedge clk) disable iff (rst)
    cmd.term_start |-> st.term_idle)
    else $error("term unit started while busy");
  a_clear_first: assert property (@(posedge clk)
    $past(rst) && !rst |-> state == ltgs_pkg::S_CLEAR)
    else $error("clearing pass skipped after reset");
`endif

endmodule

/* test/lda_token_gibbs_sampler_core_checker.sv */
`timescale 1ns / 1ps
// Result checker for the LDA token Gibbs sampler: follows the config, input and output channels.
// Predicts each transaction's topic and count error; depends on ltgs_pkg.
module lda_token_gibbs_sampler_core_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  logic [ltgs_pkg::ACT_W-1:0]       action,
  input  logic [ltgs_pkg::DOC_W-1:0]       doc_index,
  input  logic [ltgs_pkg::WORD_W-1:0]      word_index,
  input  logic [ltgs_pkg::TOPIC_W-1:0]     topic_in,
  input  logic [ltgs_pkg::WT_W-1:0]        doc_weight,
  input  logic [ltgs_pkg::WT_W-1:0]        uniform_draw,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  logic [ltgs_pkg::TOPIC_W-1:0]     topic_out,
  input  logic                             count_error,
  input  logic                             cfg_valid,
  input  logic                             cfg_ready,
  input  logic [ltgs_pkg::CFG_IW-1:0]      cfg_index,
  input  logic [ltgs_pkg::PRIOR_W-1:0]     cfg_data,
  output int                               fail_count,
  output int                               pending
);

  typedef struct {
    logic [ltgs_pkg::TOPIC_W-1:0] topic;
    logic                         err;
  } sample_t;

  bit [ltgs_pkg::CNT_W-1:0]   doc_cnt  [ltgs_pkg::DOC_DEPTH*ltgs_pkg::NUM_TOPICS];
  bit [ltgs_pkg::CNT_W-1:0]   word_cnt [ltgs_pkg::VOCAB_DEPTH*ltgs_pkg::NUM_TOPICS];
  bit [ltgs_pkg::CNT_W-1:0]   total_cnt[ltgs_pkg::NUM_TOPICS];
  bit [ltgs_pkg::WT_W-1:0]    doc_wt   [ltgs_pkg::DOC_DEPTH*ltgs_pkg::NUM_TOPICS];
  bit [ltgs_pkg::CUM_W-1:0]   run_sum  [ltgs_pkg::NUM_TOPICS];
  bit [ltgs_pkg::PRIOR_W-1:0] alpha;
  bit [ltgs_pkg::PRIOR_W-1:0] beta;
  bit [ltgs_pkg::VOCAB_W-1:0] vocab;
  sample_t                    sample_q[$];
  int                         fails;

  assign fail_count = fails;

  task automatic report_mismatch(input string msg);
    $display("[%0t] mismatch: %s", $realtime, msg);
    fails++;
  endtask

  function automatic bit [ltgs_pkg::TERM_W-1:0] topic_weight(
    bit [ltgs_pkg::CNT_W-1:0] cd, bit [ltgs_pkg::CNT_W-1:0] cw,
    bit [ltgs_pkg::CNT_W-1:0] ck, bit [ltgs_pkg::WT_W-1:0] dp);
    bit [127:0] a, b, d, prod, den, q;
    a = (128'(cd) << 16) + 128'(alpha);
    b = (128'(cw) << 16) + 128'(beta);
    d = (128'(ck) << 16) + 128'(beta) * 128'(vocab);
    prod = a * b * 128'(dp);
    den = d << 16;
    if (den == 0) return (prod == 0) ? '0 : ltgs_pkg::TERM_MAX;
    q = prod / den;
    if ((q >> ltgs_pkg::TERM_W) != 0) return ltgs_pkg::TERM_MAX;
    return q[ltgs_pkg::TERM_W-1:0];
  endfunction

  function automatic void bump(ref bit [ltgs_pkg::CNT_W-1:0] c);
    if (c != ltgs_pkg::CNT_MAX) c++;
  endfunction

  function automatic bit drop(ref bit [ltgs_pkg::CNT_W-1:0] c);
    if (c == 0) return 1'b1;
    c--;
    return 1'b0;
  endfunction

  function automatic sample_t predict_token(
    bit [ltgs_pkg::ACT_W-1:0] act, bit [ltgs_pkg::DOC_W-1:0] doc,
    bit [ltgs_pkg::WORD_W-1:0] word, bit [ltgs_pkg::TOPIC_W-1:0] tp,
    bit [ltgs_pkg::WT_W-1:0] wt, bit [ltgs_pkg::WT_W-1:0] u);
    sample_t                   r;
    int                        db, wb, k;
    bit [ltgs_pkg::CUM_W-1:0]  sum;
    bit [ltgs_pkg::TERM_W-1:0] t;
    bit [127:0]                target;
    r.topic = tp;
    r.err = 1'b0;
    db = int'(doc) * ltgs_pkg::NUM_TOPICS;
    wb = int'(word) * ltgs_pkg::NUM_TOPICS;
    if (act == ltgs_pkg::ACT_COUNT) begin
      bump(doc_cnt[db + tp]);
      bump(word_cnt[wb + tp]);
      bump(total_cnt[tp]);
    end else if (act == ltgs_pkg::ACT_WEIGHT) begin
      doc_wt[db + tp] = wt;
    end else if (act == ltgs_pkg::ACT_RESAMPLE) begin
      r.err |= drop(doc_cnt[db + tp]);
      r.err |= drop(word_cnt[wb + tp]);
      r.err |= drop(total_cnt[tp]);
      sum = '0;
      for (k = 0; k < ltgs_pkg::NUM_TOPICS; k++) begin
        t = topic_weight(doc_cnt[db + k], word_cnt[wb + k], total_cnt[k], doc_wt[db + k]);
        sum = (ltgs_pkg::CUM_W'(t) > ltgs_pkg::CUM_MAX - sum) ? ltgs_pkg::CUM_MAX
                                                             : sum + ltgs_pkg::CUM_W'(t);
        run_sum[k] = sum;
      end
      target = (128'(sum) * 128'(u)) >> 16;
      k = 0;
      while (k + 1 < ltgs_pkg::NUM_TOPICS && target > 128'(run_sum[k])) k++;
      r.topic = k[ltgs_pkg::TOPIC_W-1:0];
      bump(doc_cnt[db + k]);
      bump(word_cnt[wb + k]);
      bump(total_cnt[k]);
    end
    return r;
  endfunction

  always @(posedge clk) begin
    sample_t got, want, next_item;
    if (rst) begin
      alpha = ltgs_pkg::ALPHA_RESET;
      beta = ltgs_pkg::BETA_RESET;
      vocab = ltgs_pkg::VOCAB_RESET;
      sample_q.delete();
      pending <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ltgs_pkg::CFG_ALPHA: alpha = cfg_data;
          ltgs_pkg::CFG_BETA:  beta = cfg_data;
          ltgs_pkg::CFG_VOCAB: vocab = cfg_data[ltgs_pkg::VOCAB_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        got.topic = topic_out;
        got.err = count_error;
        if (sample_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result topic %0d", got.topic));
        end else begin
          want = sample_q.pop_front();
          if (got.topic !== want.topic)
            report_mismatch($sformatf("topic_out %0d, want %0d", got.topic, want.topic));
          if (got.err !== want.err)
            report_mismatch($sformatf("count_error %0b, want %0b", got.err, want.err));
        end
      end
      if (in_valid && !in_stall) begin
        next_item = predict_token(action, doc_index, word_index, topic_in,
                                  doc_weight, uniform_draw);
        sample_q.insert(sample_q.size(), next_item);
      end
      pending <= sample_q.size();
    end
  end

  initial fails = 0;

endmodule

/* test/lda_token_gibbs_sampler_core_tb.sv */
`timescale 1ns / 1ps
// Testbench top for lda_token_gibbs_sampler_core: clock, reset, stimulus and verdict.
// Depends on ltgs_pkg and lda_token_gibbs_sampler_core_checker.
module lda_token_gibbs_sampler_core_tb;

  localparam int WATCHDOG_LIMIT = 2_000_000;

  logic                              clk = 1'b0;
  logic                              rst = 1'b1;
  logic                              in_valid = 1'b0;
  logic                              in_stall;
  logic [ltgs_pkg::ACT_W-1:0]        action = '0;
  logic [ltgs_pkg::DOC_W-1:0]        doc_index = '0;
  logic [ltgs_pkg::WORD_W-1:0]       word_index = '0;
  logic [ltgs_pkg::TOPIC_W-1:0]      topic_in = '0;
  logic [ltgs_pkg::WT_W-1:0]         doc_weight = '0;
  logic [ltgs_pkg::WT_W-1:0]         uniform_draw = '0;
  logic                              out_valid;
  logic                              out_stall = 1'b0;
  logic [ltgs_pkg::TOPIC_W-1:0]      topic_out;
  logic                              count_error;
  logic                              cfg_valid = 1'b0;
  logic                              cfg_ready;
  logic [ltgs_pkg::CFG_IW-1:0]       cfg_index = '0;
  logic [ltgs_pkg::PRIOR_W-1:0]      cfg_data = '0;
  int                                fail_count;
  int                                pending;

  bit calm = 1'b0;
  bit hold_req = 1'b0;
  bit hold_done = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int tokens_sent = 0;
  int resamples_sent = 0;
  int sample_docs[4] = '{0, 1, 512, 1023};

  always #10 clk = ~clk;

  lda_token_gibbs_sampler_core i_dut (.*);

  lda_token_gibbs_sampler_core_checker i_checker (.*);

  // receiver: random stall, one long hold on request
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_req && !hold_done && hold_left == 0 && !out_stall) begin
      hold_left <= 600;
      hold_done <= 1'b1;
      out_stall <= 1'b1;
    end else if (hold_left > 1) begin
      hold_left <= hold_left - 1;
      out_stall <= 1'b1;
    end else begin
      hold_left <= 0;
      out_stall <= calm ? 1'b0 : ($urandom_range(0, 99) < 33);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("lda_token_gibbs_sampler_core_tb: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [ltgs_pkg::CFG_IW-1:0] idx,
                           input logic [ltgs_pkg::PRIOR_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic send_token(input logic [ltgs_pkg::ACT_W-1:0] act, input int doc,
                            input int word, input int tp, input int wt, input int u);
    while (!calm && $urandom_range(0, 99) < 33) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    action <= act;
    doc_index <= doc[ltgs_pkg::DOC_W-1:0];
    word_index <= word[ltgs_pkg::WORD_W-1:0];
    topic_in <= tp[ltgs_pkg::TOPIC_W-1:0];
    doc_weight <= wt[ltgs_pkg::WT_W-1:0];
    uniform_draw <= u[ltgs_pkg::WT_W-1:0];
    do @(negedge clk); while (in_stall);
    @(posedge clk);
    tokens_sent++;
    if (act == ltgs_pkg::ACT_RESAMPLE) resamples_sent++;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic set_priors(input int a, input int b, input int v);
    write_reg(ltgs_pkg::CFG_ALPHA, a[ltgs_pkg::PRIOR_W-1:0]);
    write_reg(ltgs_pkg::CFG_BETA, b[ltgs_pkg::PRIOR_W-1:0]);
    write_reg(ltgs_pkg::CFG_VOCAB, v[ltgs_pkg::PRIOR_W-1:0]);
  endtask

  task automatic random_token();
    int pick, doc, word, u;
    pick = $urandom_range(0, 99);
    doc = sample_docs[$urandom_range(0, 3)];
    word = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 8191) : $urandom_range(0, 15);
    u = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 65535 : 0)
                                    : $urandom_range(0, 65535);
    if (pick < 50)
      send_token(ltgs_pkg::ACT_COUNT, doc, word, $urandom_range(0, 63), $urandom, $urandom);
    else if (pick < 62)
      send_token(ltgs_pkg::ACT_COUNT, $urandom_range(0, 1023), $urandom_range(0, 8191),
                 $urandom_range(0, 63), $urandom, $urandom);
    else if (pick < 82)
      send_token(ltgs_pkg::ACT_WEIGHT, $urandom_range(0, 1) ? doc : $urandom_range(0, 1023),
                 $urandom, $urandom_range(0, 63), $urandom_range(0, 65535), $urandom);
    else if (pick < 87)
      send_token(ltgs_pkg::ACT_RESAMPLE, doc, word, $urandom_range(0, 63), $urandom, u);
    else
      send_token(ltgs_pkg::ACT_UNUSED, $urandom_range(0, 1023), $urandom_range(0, 8191),
                 $urandom_range(0, 63), $urandom, $urandom);
  endtask

  task automatic random_phase(input int count);
    repeat (count) random_token();
    drain();
  endtask

  initial begin
    int t;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    set_priors(6554, 655, 8192);

    // load every weight of the documents that get resampled
    foreach (sample_docs[d])
      for (t = 0; t < ltgs_pkg::NUM_TOPICS; t++)
        send_token(ltgs_pkg::ACT_WEIGHT, sample_docs[d], 0, t,
                   (t == 0) ? 0 : (t == 63) ? 65535 : $urandom_range(1, 65534), 0);

    send_token(ltgs_pkg::ACT_RESAMPLE, 0, 0, 0, 0, 0);
    send_token(ltgs_pkg::ACT_RESAMPLE, 1023, 8191, 63, 0, 65535);
    send_token(ltgs_pkg::ACT_COUNT, 1023, 8191, 63, 0, 0);
    send_token(ltgs_pkg::ACT_COUNT, 1023, 8191, 63, 65535, 65535);
    send_token(ltgs_pkg::ACT_COUNT, 0, 0, 0, 0, 0);
    send_token(ltgs_pkg::ACT_RESAMPLE, 1023, 8191, 63, 0, 0);
    send_token(ltgs_pkg::ACT_RESAMPLE, 0, 0, 0, 65535, 65535);
    send_token(ltgs_pkg::ACT_WEIGHT, 1, 0, 0, 65535, 0);
    send_token(ltgs_pkg::ACT_WEIGHT, 1, 8191, 63, 0, 65535);
    send_token(ltgs_pkg::ACT_COUNT, 1, 5, 0, 0, 0);
    send_token(ltgs_pkg::ACT_RESAMPLE, 1, 5, 0, 0, 32768);
    send_token(ltgs_pkg::ACT_UNUSED, 1023, 8191, 63, 65535, 65535);
    send_token(ltgs_pkg::ACT_UNUSED, 0, 0, 0, 0, 0);
    drain();

    random_phase(350);
    set_priors(24'hFFFFFF, 24'hFFFFFF, 8192);
    calm = 1'b1;
    random_phase(300);
    calm = 1'b0;
    set_priors(0, 0, 1);
    hold_req = 1'b1;
    random_phase(300);
    set_priors(0, 1, 1);
    random_phase(200);
    set_priors($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFF),
               $urandom_range(1, 8192));
    random_phase(300);
    set_priors(6554, 655, 8192);
    random_phase(150);

    repeat (20) @(posedge clk);
    $display("Covered %0d transactions, %0d of them resamples, over six prior settings.",
             tokens_sent, resamples_sent);
    $display("Included long output hold, stall-free stretch and full drains between phases.");
    if (fail_count == 0) begin
      $display("lda_token_gibbs_sampler_core_tb: PASS");
    end else begin
      $display("lda_token_gibbs_sampler_core_tb: FAIL");
    end
    $finish;
  end

endmodule
